FILE: design/ptm_pkg.sv
// shared types and constants of the polyphonic triangle mixer
// note step table, lane value width and the control bundle to the merge stage
// no dependencies
package ptm_pkg;

  localparam int unsigned MAX_NOTES = 12;
  localparam int unsigned TRI_W     = 9;
  localparam int unsigned PHASE_W   = 32;
  localparam int unsigned KEY_W     = 12;
  localparam int unsigned VOL_W     = 4;
  localparam int unsigned SAMPLE_W  = 8;

  typedef struct packed {
    logic load_grp;
    logic load_tot;
  } ptm_ctl_t;

  function automatic logic [PHASE_W-1:0] note_step(input int unsigned idx);
    logic [PHASE_W-1:0] step;
    case (idx)
      0:       step = 32'd51076057;
      1:       step = 32'd54113197;
      2:       step = 32'd57330935;
      3:       step = 32'd60740010;
      4:       step = 32'd64351799;
      5:       step = 32'd68178356;
      6:       step = 32'd72232452;
      7:       step = 32'd76527617;
      8:       step = 32'd81078186;
      9:       step = 32'd85899346;
      10:      step = 32'd91007187;
      11:      step = 32'd96418756;
      default: step = '0;
    endcase
    return step;
  endfunction

endpackage

FILE: design/ptm_lane.sv
// one voice lane: phase accumulator with fixed step and triangle shaper
// depends on ptm_pkg
module ptm_lane #(
  parameter logic [31:0] STEP = 32'd51076057
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               advance,
  output logic signed [ptm_pkg::TRI_W-1:0]   tri_o
);
  import ptm_pkg::*;

  logic [PHASE_W-1:0] phase_r;
  logic [PHASE_W-1:0] phase_nxt;
  logic [7:0]         x;
  logic [7:0]         t;

  always_comb begin
    phase_nxt = phase_r;
    if (advance) begin
      phase_nxt = phase_r + STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  assign x     = phase_r[PHASE_W-1 -: 8];
  assign t     = x[7] ? ~x : x;
  assign tri_o = $signed({1'b0, t[6:0], 1'b0}) - $signed(TRI_W'(128));

endmodule

FILE: design/ptm_merge.sv
// merge stage: sums the sounding lanes through a two-level registered tree
// and counts the voices; depends on ptm_pkg
module ptm_merge #(
  parameter int unsigned LANES = 24,
  parameter int unsigned SUM_W = 13,
  parameter int unsigned CNT_W = 5
) (
  input  logic                              clk,
  input  ptm_pkg::ptm_ctl_t                 ctl,
  input  logic signed [ptm_pkg::TRI_W-1:0]  lane_tri [LANES],
  input  logic [LANES-1:0]                  mask,
  output logic signed [SUM_W-1:0]           sum_o,
  output logic [CNT_W-1:0]                  cnt_o
);
  import ptm_pkg::*;

  localparam int unsigned GRP   = (LANES + 3) / 4;
  localparam int unsigned GRP_W = TRI_W + 2;

  logic signed [GRP_W-1:0] grp_r   [GRP];
  logic signed [GRP_W-1:0] grp_nxt [GRP];
  logic signed [SUM_W-1:0] sum_r;
  logic signed [SUM_W-1:0] sum_nxt;
  logic [CNT_W-1:0]        cnt_r;

  always_comb begin
    for (int g = 0; g < GRP; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < 4; k++) begin
        if (g * 4 + k < LANES) begin
          if (mask[g * 4 + k]) begin
            grp_nxt[g] = grp_nxt[g] + GRP_W'(lane_tri[g * 4 + k]);
          end
        end
      end
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int g = 0; g < GRP; g++) begin
      sum_nxt = sum_nxt + SUM_W'(grp_r[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_grp) begin
      grp_r <= grp_nxt;
    end
    if (ctl.load_tot) begin
      sum_r <= sum_nxt;
      cnt_r <= CNT_W'($countones(mask));
    end
  end

  assign sum_o = sum_r;
  assign cnt_o = cnt_r;

endmodule

FILE: design/ptm_div.sv
// iterative signed divider, one quotient bit per cycle, truncating toward zero
// no dependencies
module ptm_div #(
  parameter int unsigned SUM_W = 13,
  parameter int unsigned CNT_W = 5
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0]        divisor,
  output logic signed [SUM_W-1:0] quot,
  output logic                    done
);

  localparam int unsigned CW = (SUM_W > 1) ? $clog2(SUM_W) : 1;

  logic             busy_r;
  logic             done_r;
  logic [CW-1:0]    cnt_r;
  logic             neg_r;
  logic [CNT_W-1:0] div_r;
  logic [CNT_W:0]   rem_r;
  logic [CNT_W:0]   rem_nxt;
  logic [SUM_W-1:0] quo_r;
  logic [SUM_W-1:0] quo_nxt;
  logic [CNT_W:0]   rem_sh;
  logic [SUM_W-1:0] mag;

  assign mag    = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
  assign rem_sh = {rem_r[CNT_W-1:0], quo_r[SUM_W-1]};

  always_comb begin
    if (rem_sh >= {1'b0, div_r}) begin
      rem_nxt = rem_sh - {1'b0, div_r};
      quo_nxt = {quo_r[SUM_W-2:0], 1'b1};
    end else begin
      rem_nxt = rem_sh;
      quo_nxt = {quo_r[SUM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(SUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[SUM_W-1];
      div_r <= divisor;
      rem_r <= '0;
      quo_r <= mag;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quot = neg_r ? -$signed(quo_r) : $signed(quo_r);
  assign done = done_r;

endmodule

FILE: design/polyphonic_triangle_mixer_top.sv
// top level of the polyphonic triangle mixer: lanes, merge, divider, output stage
// depends on ptm_pkg, ptm_lane, ptm_merge, ptm_div
//
// One input beat is one sample tick and yields one output beat. Each key bit
// drives its own lane (local notes, then remote notes), so the phase
// accumulators of the set key bits advance in the accept cycle; the merge tree
// then registers the group sums and the total, and the voice-count divider
// works through the bits of the sum before the result is registered in the
// output stage. The divider loop is the longest of these steps. A new tick is
// taken as soon as the previous one has reached the output register, even
// while that result still waits for out_tready.
module polyphonic_triangle_mixer_top #(
  parameter int unsigned NOTE_COUNT = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // local_keys[11:0], remote_keys[23:12], volume[27:24]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // sample[7:0]
);
  import ptm_pkg::*;

  localparam int unsigned LANES = 2 * NOTE_COUNT;
  localparam int unsigned CNT_W = $clog2(LANES + 1);
  localparam int unsigned SUM_W = $clog2(128 * LANES + 1) + 1;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_GRP    = 6'b000010,
    S_TOT    = 6'b000100,
    S_DSTART = 6'b001000,
    S_DWAIT  = 6'b010000,
    S_FIN    = 6'b100000
  } state_t;

  state_t                  state_r;
  state_t                  state_nxt;
  logic                    in_acc;
  logic                    out_free;
  logic [LANES-1:0]        keys_all;
  logic [LANES-1:0]        key_r;
  logic [VOL_W-1:0]        vol_r;
  logic signed [TRI_W-1:0] lane_tri [LANES];
  ptm_ctl_t                ctl;
  logic signed [SUM_W-1:0] sum;
  logic [CNT_W-1:0]        cnt;
  logic signed [SUM_W-1:0] quot;
  logic                    div_done;
  logic                    out_tvalid_r;
  logic [SAMPLE_W-1:0]     sample_r;
  logic [SAMPLE_W-1:0]     sample_nxt;
  logic signed [TRI_W-1:0] mix;
  logic signed [TRI_W-1:0] mix_sh;
  logic [3:0]              sh;
  logic signed [TRI_W:0]   res;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  assign keys_all  = {in_tdata[KEY_W +: NOTE_COUNT], in_tdata[0 +: NOTE_COUNT]};

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    ptm_lane #(
      .STEP(ptm_pkg::note_step(i % NOTE_COUNT))
    ) u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .advance(in_acc && keys_all[i]),
      .tri_o  (lane_tri[i])
    );
  end

  assign ctl.load_grp = (state_r == S_GRP);
  assign ctl.load_tot = (state_r == S_TOT);

  ptm_merge #(
    .LANES(LANES),
    .SUM_W(SUM_W),
    .CNT_W(CNT_W)
  ) u_merge (
    .clk     (clk),
    .ctl     (ctl),
    .lane_tri(lane_tri),
    .mask    (key_r),
    .sum_o   (sum),
    .cnt_o   (cnt)
  );

  ptm_div #(
    .SUM_W(SUM_W),
    .CNT_W(CNT_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (state_r == S_DSTART),
    .dividend(sum),
    .divisor (cnt),
    .quot    (quot),
    .done    (div_done)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_acc) state_nxt = S_GRP;
      S_GRP:    state_nxt = S_TOT;
      S_TOT:    state_nxt = S_DSTART;
      S_DSTART: state_nxt = S_DWAIT;
      S_DWAIT:  if (div_done) state_nxt = S_FIN;
      S_FIN:    if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    mix    = quot[TRI_W-1:0];
    sh     = (vol_r >= 4'd8) ? 4'd0 : (4'd8 - vol_r);
    mix_sh = mix >>> sh;
    res    = (TRI_W + 1)'(mix_sh) + $signed((TRI_W + 1)'(128));
    if (cnt == '0) begin
      sample_nxt = SAMPLE_W'(128);
    end else if (res < 0) begin
      sample_nxt = '0;
    end else if (res > $signed((TRI_W + 1)'(255))) begin
      sample_nxt = '1;
    end else begin
      sample_nxt = res[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_FIN && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      key_r <= keys_all;
      vol_r <= in_tdata[2 * KEY_W +: VOL_W];
    end
    if (state_r == S_FIN && out_free) begin
      sample_r <= sample_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = sample_r;

  a_accept_to_grp: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_GRP)
    else $error("accepted beat did not enter the merge stage");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DWAIT)
    else $error("divider finished outside of its wait state");

  a_fin_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_free) |=> out_tvalid && state_r == S_IDLE)
    else $error("finished result not presented");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DSTART) |-> cnt <= CNT_W'(LANES))
    else $error("voice count exceeds lane count");

endmodule
